>>> sv/l2_l4_header_field_extractor_core_defines.svh
// Assertion macros shared by the extractor RTL.
`ifndef L2_L4_HEADER_FIELD_EXTRACTOR_CORE_DEFINES_SVH
`define L2_L4_HEADER_FIELD_EXTRACTOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define L2X_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define L2X_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/l2x_pkg.sv
package l2x_pkg;

    typedef enum logic [3:0] {
        PH_ETH  = 4'd0,
        PH_VLAN = 4'd1,
        PH_IP4  = 4'd2,
        PH_IP6  = 4'd3,
        PH_UDP  = 4'd4,
        PH_TCP  = 4'd5,
        PH_ICMP = 4'd6
    } phase_t;

    localparam logic [4:0] FID_DMAC     = 5'd0;
    localparam logic [4:0] FID_SMAC     = 5'd1;
    localparam logic [4:0] FID_TCI      = 5'd2;
    localparam logic [4:0] FID_IP4_SRC  = 5'd3;
    localparam logic [4:0] FID_IP4_DST  = 5'd4;
    localparam logic [4:0] FID_IP6_SRCH = 5'd5;
    localparam logic [4:0] FID_IP6_SRCL = 5'd6;
    localparam logic [4:0] FID_IP6_DSTH = 5'd7;
    localparam logic [4:0] FID_IP6_DSTL = 5'd8;
    localparam logic [4:0] FID_SPORT    = 5'd9;
    localparam logic [4:0] FID_DPORT    = 5'd10;
    localparam logic [4:0] FID_TCP_SEQ  = 5'd11;
    localparam logic [4:0] FID_TCP_ACK  = 5'd12;
    localparam logic [4:0] FID_TCP_FLG  = 5'd13;
    localparam logic [4:0] FID_ICMP_TYP = 5'd14;
    localparam logic [4:0] FID_ICMP_COD = 5'd15;
    localparam logic [4:0] FID_END      = 5'd16;

    localparam logic [1:0] L3_NONE = 2'd0;
    localparam logic [1:0] L3_IP4  = 2'd1;
    localparam logic [1:0] L3_IP6  = 2'd2;

    localparam logic [1:0] L4_NONE = 2'd0;
    localparam logic [1:0] L4_UDP  = 2'd1;
    localparam logic [1:0] L4_TCP  = 2'd2;
    localparam logic [1:0] L4_ICMP = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;

    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_IP4  = 16'h0800;
    localparam logic [15:0] ETYPE_IP6  = 16'h86DD;

    localparam logic [15:0] PROTO_ICMP = 16'd1;
    localparam logic [15:0] PROTO_TCP  = 16'd6;
    localparam logic [15:0] PROTO_UDP  = 16'd17;

    localparam logic [5:0] LEN_ETH  = 6'd14;
    localparam logic [5:0] LEN_VLAN = 6'd4;
    localparam logic [5:0] LEN_IP4  = 6'd20;
    localparam logic [5:0] LEN_IP6  = 6'd40;
    localparam logic [5:0] LEN_UDP  = 6'd8;
    localparam logic [5:0] LEN_TCP  = 6'd20;
    localparam logic [5:0] LEN_ICMP = 6'd8;

    localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

endpackage

>>> sv/l2_l4_header_field_extractor_core.sv
// Streaming header parser for Ethernet, one VLAN tag, IPv4 or IPv6, and UDP, TCP or ICMP.
// One packet byte is taken in every clock cycle while s_ready is high; each request is parsed
// in the cycle it is accepted and its result, if any, appears in the output register on the
// next cycle, so the sustained rate is one byte per cycle. The only thing that slows the input
// is the single output register: s_ready is high whenever that register is empty or its request
// is being taken in the same cycle. Every packet closes with one end record; where it coincides
// with a field it follows one byte later.
`include "l2_l4_header_field_extractor_core_defines.svh"

module l2_l4_header_field_extractor_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_field_id,
    output logic [63:0] m_field_value,
    output logic [1:0]  m_l3_kind,
    output logic [1:0]  m_l4_kind,
    output logic [1:0]  m_parse_status,
    output logic        m_headers_done
);

    l2x_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  byte_offset_reg, byte_offset_next;
    logic [63:0] field_shift_reg, field_shift_next;
    logic [15:0] next_type_reg, next_type_next;
    logic [7:0]  hdr_end_reg, hdr_end_next;
    logic [1:0]  l3_seen_reg, l3_seen_next;
    logic [1:0]  l4_seen_reg, l4_seen_next;
    logic        skip_reg, skip_next;
    logic [5:0]  cur_len_reg, cur_len_next;

    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_value_reg, pend_value_next;
    logic [1:0]  pend_l3_reg, pend_l3_next;
    logic [1:0]  pend_l4_reg, pend_l4_next;
    logic [1:0]  pend_status_reg, pend_status_next;

    logic        m_valid_reg, m_valid_next;
    logic [4:0]  m_field_id_reg, m_field_id_next;
    logic [63:0] m_field_value_reg, m_field_value_next;
    logic [1:0]  m_l3_kind_reg, m_l3_kind_next;
    logic [1:0]  m_l4_kind_reg, m_l4_kind_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic        m_done_reg, m_done_next;

    logic        accept;
    logic        produce;
    logic [7:0]  rel;
    logic [63:0] shift_mid;
    logic [15:0] type_mid;
    logic [5:0]  len_mid;
    logic        have_field;
    logic        end_now;
    logic        bad;
    logic        finish;
    logic [4:0]  fid;
    logic [63:0] fval;
    logic [1:0]  status;
    logic [7:0]  e_val;
    logic [1:0]  e_l3;
    logic [1:0]  e_l4;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign rel       = byte_offset_reg - hdr_end_reg;
    assign shift_mid = {field_shift_reg[55:0], s_data_byte};

    always_comb begin
        phase_next         = phase_reg;
        byte_offset_next   = byte_offset_reg;
        field_shift_next   = field_shift_reg;
        next_type_next     = next_type_reg;
        hdr_end_next       = hdr_end_reg;
        l3_seen_next       = l3_seen_reg;
        l4_seen_next       = l4_seen_reg;
        skip_next          = skip_reg;
        cur_len_next       = cur_len_reg;
        pend_valid_next    = pend_valid_reg;
        pend_value_next    = pend_value_reg;
        pend_l3_next       = pend_l3_reg;
        pend_l4_next       = pend_l4_reg;
        pend_status_next   = pend_status_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_field_id_next    = m_field_id_reg;
        m_field_value_next = m_field_value_reg;
        m_l3_kind_next     = m_l3_kind_reg;
        m_l4_kind_next     = m_l4_kind_reg;
        m_status_next      = m_status_reg;
        m_done_next        = m_done_reg;
        type_mid           = next_type_reg;
        len_mid            = cur_len_reg;
        have_field         = 1'b0;
        end_now            = 1'b0;
        bad                = 1'b0;
        finish             = 1'b0;
        fid                = l2x_pkg::FID_DMAC;
        fval               = '0;
        status             = l2x_pkg::ST_OK;
        produce            = 1'b0;
        e_val              = '0;
        e_l3               = '0;
        e_l4               = '0;

        if (accept) begin
            if (!skip_reg) begin
                field_shift_next = shift_mid;
                unique case (phase_reg)
                    l2x_pkg::PH_ETH: begin
                        if (rel == 8'd5) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_DMAC;
                            fval       = {16'd0, shift_mid[47:0]};
                        end else if (rel == 8'd11) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_SMAC;
                            fval       = {16'd0, shift_mid[47:0]};
                        end else if (rel == 8'd13) begin
                            type_mid = shift_mid[15:0];
                        end
                    end
                    l2x_pkg::PH_VLAN: begin
                        if (rel == 8'd1) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_TCI;
                            fval       = {48'd0, shift_mid[15:0]};
                        end else if (rel == 8'd3) begin
                            type_mid = shift_mid[15:0];
                        end
                    end
                    l2x_pkg::PH_IP4: begin
                        if (rel == 8'd0) begin
                            if (s_data_byte[3:0] < l2x_pkg::MIN_HDR_WORDS) begin
                                bad = 1'b1;
                            end else begin
                                len_mid = {s_data_byte[3:0], 2'b00};
                            end
                        end else if (rel == 8'd9) begin
                            type_mid = {8'd0, s_data_byte};
                        end else if (rel == 8'd15) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_IP4_SRC;
                            fval       = {32'd0, shift_mid[31:0]};
                        end else if (rel == 8'd19) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_IP4_DST;
                            fval       = {32'd0, shift_mid[31:0]};
                        end
                    end
                    l2x_pkg::PH_IP6: begin
                        fval = shift_mid;
                        if (rel == 8'd6) begin
                            type_mid = {8'd0, s_data_byte};
                        end else if (rel == 8'd15) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_IP6_SRCH;
                        end else if (rel == 8'd23) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_IP6_SRCL;
                        end else if (rel == 8'd31) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_IP6_DSTH;
                        end else if (rel == 8'd39) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_IP6_DSTL;
                        end
                    end
                    l2x_pkg::PH_UDP: begin
                        if (rel == 8'd1) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_SPORT;
                            fval       = {48'd0, shift_mid[15:0]};
                        end else if (rel == 8'd3) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_DPORT;
                            fval       = {48'd0, shift_mid[15:0]};
                        end
                    end
                    l2x_pkg::PH_TCP: begin
                        if (rel == 8'd1) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_SPORT;
                            fval       = {48'd0, shift_mid[15:0]};
                        end else if (rel == 8'd3) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_DPORT;
                            fval       = {48'd0, shift_mid[15:0]};
                        end else if (rel == 8'd7) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_TCP_SEQ;
                            fval       = {32'd0, shift_mid[31:0]};
                        end else if (rel == 8'd11) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_TCP_ACK;
                            fval       = {32'd0, shift_mid[31:0]};
                        end else if (rel == 8'd12) begin
                            if (s_data_byte[7:4] < l2x_pkg::MIN_HDR_WORDS) begin
                                bad = 1'b1;
                            end else begin
                                len_mid = {s_data_byte[7:4], 2'b00};
                            end
                        end else if (rel == 8'd13) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_TCP_FLG;
                            fval       = {56'd0, s_data_byte};
                        end
                    end
                    default: begin
                        if (rel == 8'd0) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_ICMP_TYP;
                            fval       = {56'd0, s_data_byte};
                        end else if (rel == 8'd1) begin
                            have_field = 1'b1;
                            fid        = l2x_pkg::FID_ICMP_COD;
                            fval       = {56'd0, s_data_byte};
                        end
                    end
                endcase

                next_type_next = type_mid;
                cur_len_next   = len_mid;

                if (bad) begin
                    end_now = 1'b1;
                    status  = l2x_pkg::ST_BAD_LEN;
                end else if (rel == ({2'b00, len_mid} - 8'd1)) begin
                    hdr_end_next = byte_offset_reg + 8'd1;
                    if (phase_reg == l2x_pkg::PH_ETH || phase_reg == l2x_pkg::PH_VLAN) begin
                        if (phase_reg == l2x_pkg::PH_ETH && type_mid == l2x_pkg::ETYPE_VLAN) begin
                            phase_next   = l2x_pkg::PH_VLAN;
                            cur_len_next = l2x_pkg::LEN_VLAN;
                        end else if (type_mid == l2x_pkg::ETYPE_IP4) begin
                            phase_next   = l2x_pkg::PH_IP4;
                            cur_len_next = l2x_pkg::LEN_IP4;
                            l3_seen_next = l2x_pkg::L3_IP4;
                        end else if (type_mid == l2x_pkg::ETYPE_IP6) begin
                            phase_next   = l2x_pkg::PH_IP6;
                            cur_len_next = l2x_pkg::LEN_IP6;
                            l3_seen_next = l2x_pkg::L3_IP6;
                        end else begin
                            finish = 1'b1;
                        end
                    end else if (phase_reg == l2x_pkg::PH_IP4 || phase_reg == l2x_pkg::PH_IP6) begin
                        if (type_mid == l2x_pkg::PROTO_UDP) begin
                            phase_next   = l2x_pkg::PH_UDP;
                            cur_len_next = l2x_pkg::LEN_UDP;
                            l4_seen_next = l2x_pkg::L4_UDP;
                        end else if (type_mid == l2x_pkg::PROTO_TCP) begin
                            phase_next   = l2x_pkg::PH_TCP;
                            cur_len_next = l2x_pkg::LEN_TCP;
                            l4_seen_next = l2x_pkg::L4_TCP;
                        end else if (type_mid == l2x_pkg::PROTO_ICMP &&
                                     phase_reg == l2x_pkg::PH_IP4) begin
                            phase_next   = l2x_pkg::PH_ICMP;
                            cur_len_next = l2x_pkg::LEN_ICMP;
                            l4_seen_next = l2x_pkg::L4_ICMP;
                        end else begin
                            finish = 1'b1;
                        end
                    end else begin
                        finish = 1'b1;
                    end
                    if (finish) begin
                        end_now = 1'b1;
                        status  = l2x_pkg::ST_OK;
                    end
                end

                if (!end_now && s_last_byte) begin
                    end_now = 1'b1;
                    status  = l2x_pkg::ST_TRUNC;
                end
                if (end_now) begin
                    skip_next = 1'b1;
                end
                if (byte_offset_reg != 8'hFF) begin
                    byte_offset_next = byte_offset_reg + 8'd1;
                end
            end

            e_val = hdr_end_next;
            e_l3  = l3_seen_next;
            e_l4  = l4_seen_next;

            if (s_last_byte) begin
                phase_next       = l2x_pkg::PH_ETH;
                byte_offset_next = '0;
                field_shift_next = '0;
                next_type_next   = '0;
                hdr_end_next     = '0;
                l3_seen_next     = l2x_pkg::L3_NONE;
                l4_seen_next     = l2x_pkg::L4_NONE;
                skip_next        = 1'b0;
                cur_len_next     = l2x_pkg::LEN_ETH;
            end

            if (pend_valid_reg) begin
                produce            = 1'b1;
                m_field_id_next    = l2x_pkg::FID_END;
                m_field_value_next = {56'd0, pend_value_reg};
                m_l3_kind_next     = pend_l3_reg;
                m_l4_kind_next     = pend_l4_reg;
                m_status_next      = pend_status_reg;
                m_done_next        = 1'b1;
            end else if (have_field) begin
                produce            = 1'b1;
                m_field_id_next    = fid;
                m_field_value_next = fval;
                m_l3_kind_next     = l3_seen_reg;
                m_l4_kind_next     = l4_seen_reg;
                m_status_next      = l2x_pkg::ST_OK;
                m_done_next        = 1'b0;
            end else if (end_now) begin
                produce            = 1'b1;
                m_field_id_next    = l2x_pkg::FID_END;
                m_field_value_next = {56'd0, e_val};
                m_l3_kind_next     = e_l3;
                m_l4_kind_next     = e_l4;
                m_status_next      = status;
                m_done_next        = 1'b1;
            end

            // An end record that shares its byte with another result waits one byte.
            pend_valid_next = (pend_valid_reg || have_field) && end_now;
            if (end_now) begin
                pend_value_next  = e_val;
                pend_l3_next     = e_l3;
                pend_l4_next     = e_l4;
                pend_status_next = status;
            end

            m_valid_next = produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= l2x_pkg::PH_ETH;
            byte_offset_reg <= '0;
            field_shift_reg <= '0;
            next_type_reg   <= '0;
            hdr_end_reg     <= '0;
            l3_seen_reg     <= l2x_pkg::L3_NONE;
            l4_seen_reg     <= l2x_pkg::L4_NONE;
            skip_reg        <= 1'b0;
            cur_len_reg     <= l2x_pkg::LEN_ETH;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            byte_offset_reg <= byte_offset_next;
            field_shift_reg <= field_shift_next;
            next_type_reg   <= next_type_next;
            hdr_end_reg     <= hdr_end_next;
            l3_seen_reg     <= l3_seen_next;
            l4_seen_reg     <= l4_seen_next;
            skip_reg        <= skip_next;
            cur_len_reg     <= cur_len_next;
            pend_valid_reg  <= pend_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_value_reg    <= pend_value_next;
        pend_l3_reg       <= pend_l3_next;
        pend_l4_reg       <= pend_l4_next;
        pend_status_reg   <= pend_status_next;
        m_field_id_reg    <= m_field_id_next;
        m_field_value_reg <= m_field_value_next;
        m_l3_kind_reg     <= m_l3_kind_next;
        m_l4_kind_reg     <= m_l4_kind_next;
        m_status_reg      <= m_status_next;
        m_done_reg        <= m_done_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_field_id     = m_field_id_reg;
    assign m_field_value  = m_field_value_reg;
    assign m_l3_kind      = m_l3_kind_reg;
    assign m_l4_kind      = m_l4_kind_reg;
    assign m_parse_status = m_status_reg;
    assign m_headers_done = m_done_reg;

    `L2X_ASSERT_NOW(a_done_is_end, m_valid_reg && m_done_reg, m_field_id_reg == l2x_pkg::FID_END, "end record has wrong field id")
    `L2X_ASSERT_NOW(a_field_status_ok, m_valid_reg && !m_done_reg, m_field_id_reg != l2x_pkg::FID_END && m_status_reg == l2x_pkg::ST_OK, "field result carries end information")
    `L2X_ASSERT_NEXT(a_last_clears, accept && s_last_byte, byte_offset_reg == 8'd0 && !skip_reg && phase_reg == l2x_pkg::PH_ETH, "packet state not cleared after last byte")
    `L2X_ASSERT_NEXT(a_pend_follows_field, accept && !pend_valid_reg && have_field && end_now, pend_valid_reg && m_valid_reg && !m_done_reg, "end record not held behind field")

endmodule

>>> bench/l2_l4_header_field_extractor_core_tb.sv
module l2_l4_header_field_extractor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [4:0]  fid;
        logic [63:0] val;
        logic [1:0]  l3;
        logic [1:0]  l4;
        logic [1:0]  st;
        logic        done;
    } field_record_t;

    localparam int FILL_RANDOM    = 0;
    localparam int FILL_ZERO      = 1;
    localparam int FILL_ONES      = 2;
    localparam int PHASE_BYTES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    class field_record_predictor;
        field_record_t   awaited[$];
        int              errors;
        int              packets;
        int              field_count;
        int              ok_ends;
        int              trunc_ends;
        int              bad_ends;
        logic [7:0]      byte_off;
        logic [7:0]      hdr_end;
        logic [7:0]      hdr_len;
        l2x_pkg::phase_t phase;
        logic [63:0]     shifter;
        logic [15:0]     nxt_type;
        logic [1:0]      l3_seen;
        logic [1:0]      l4_seen;
        logic            skipping;
        logic            held;
        logic [63:0]     held_val;
        logic [1:0]      held_l3;
        logic [1:0]      held_l4;
        logic [1:0]      held_st;

        function void clear_packet();
            byte_off = 8'd0;
            hdr_end  = 8'd0;
            hdr_len  = {2'b00, l2x_pkg::LEN_ETH};
            phase    = l2x_pkg::PH_ETH;
            shifter  = 64'd0;
            nxt_type = 16'd0;
            l3_seen  = l2x_pkg::L3_NONE;
            l4_seen  = l2x_pkg::L4_NONE;
            skipping = 1'b0;
        endfunction

        function void reset_all();
            clear_packet();
            awaited.delete();
            held     = 1'b0;
            held_val = 64'd0;
            held_l3  = l2x_pkg::L3_NONE;
            held_l4  = l2x_pkg::L4_NONE;
            held_st  = l2x_pkg::ST_OK;
            errors   = 0;
            packets  = 0;
            field_count = 0;
            ok_ends    = 0;
            trunc_ends = 0;
            bad_ends   = 0;
        endfunction

        function void enter_header(l2x_pkg::phase_t p, logic [5:0] len);
            phase   = p;
            hdr_len = {2'b00, len};
        endfunction

        function void queue_record(logic [4:0] fid, logic [63:0] val, logic [1:0] l3,
                                   logic [1:0] l4, logic [1:0] st, logic done);
            field_record_t r;
            r.fid  = fid;
            r.val  = val;
            r.l3   = l3;
            r.l4   = l4;
            r.st   = st;
            r.done = done;
            awaited.push_back(r);
            if (!done) begin
                field_count++;
            end else if (st == l2x_pkg::ST_TRUNC) begin
                trunc_ends++;
            end else if (st == l2x_pkg::ST_BAD_LEN) begin
                bad_ends++;
            end else begin
                ok_ends++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            logic            have_field;
            logic            end_now;
            logic            bad;
            logic            finish;
            logic [4:0]      fid;
            logic [63:0]     fval;
            logic [1:0]      status;
            logic [1:0]      f_l3;
            logic [1:0]      f_l4;
            logic [1:0]      e_l3;
            logic [1:0]      e_l4;
            logic [7:0]      e_val;
            logic [7:0]      rel;
            l2x_pkg::phase_t ph;

            have_field = 1'b0;
            end_now    = 1'b0;
            bad        = 1'b0;
            finish     = 1'b0;
            fid        = l2x_pkg::FID_DMAC;
            fval       = 64'd0;
            status     = l2x_pkg::ST_OK;
            f_l3       = l3_seen;
            f_l4       = l4_seen;

            if (!skipping) begin
                rel     = byte_off - hdr_end;
                shifter = {shifter[55:0], b};
                case (phase)
                    l2x_pkg::PH_ETH: begin
                        if (rel == 8'd5) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_DMAC;
                            fval = shifter & 64'hFFFF_FFFF_FFFF;
                        end else if (rel == 8'd11) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_SMAC;
                            fval = shifter & 64'hFFFF_FFFF_FFFF;
                        end else if (rel == 8'd13) begin
                            nxt_type = shifter[15:0];
                        end
                    end
                    l2x_pkg::PH_VLAN: begin
                        if (rel == 8'd1) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_TCI;
                            fval = shifter & 64'hFFFF;
                        end else if (rel == 8'd3) begin
                            nxt_type = shifter[15:0];
                        end
                    end
                    l2x_pkg::PH_IP4: begin
                        if (rel == 8'd0) begin
                            if (b[3:0] < l2x_pkg::MIN_HDR_WORDS) begin
                                bad = 1'b1;
                            end else begin
                                hdr_len = {2'b00, b[3:0], 2'b00};
                            end
                        end else if (rel == 8'd9) begin
                            nxt_type = {8'd0, b};
                        end else if (rel == 8'd15) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_IP4_SRC;
                            fval = shifter & 64'hFFFF_FFFF;
                        end else if (rel == 8'd19) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_IP4_DST;
                            fval = shifter & 64'hFFFF_FFFF;
                        end
                    end
                    l2x_pkg::PH_IP6: begin
                        if (rel == 8'd6) begin
                            nxt_type = {8'd0, b};
                        end else if (rel == 8'd15 || rel == 8'd23 || rel == 8'd31 ||
                                     rel == 8'd39) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_IP6_SRCH + 5'((rel - 8'd15) >> 3);
                            fval = shifter;
                        end
                    end
                    l2x_pkg::PH_UDP: begin
                        if (rel == 8'd1) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_SPORT;
                            fval = shifter & 64'hFFFF;
                        end else if (rel == 8'd3) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_DPORT;
                            fval = shifter & 64'hFFFF;
                        end
                    end
                    l2x_pkg::PH_TCP: begin
                        if (rel == 8'd1) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_SPORT;
                            fval = shifter & 64'hFFFF;
                        end else if (rel == 8'd3) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_DPORT;
                            fval = shifter & 64'hFFFF;
                        end else if (rel == 8'd7) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_TCP_SEQ;
                            fval = shifter & 64'hFFFF_FFFF;
                        end else if (rel == 8'd11) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_TCP_ACK;
                            fval = shifter & 64'hFFFF_FFFF;
                        end else if (rel == 8'd12) begin
                            if (b[7:4] < l2x_pkg::MIN_HDR_WORDS) begin
                                bad = 1'b1;
                            end else begin
                                hdr_len = {2'b00, b[7:4], 2'b00};
                            end
                        end else if (rel == 8'd13) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_TCP_FLG;
                            fval = {56'd0, b};
                        end
                    end
                    default: begin
                        if (rel == 8'd0) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_ICMP_TYP;
                            fval = {56'd0, b};
                        end else if (rel == 8'd1) begin
                            have_field = 1'b1;
                            fid = l2x_pkg::FID_ICMP_COD;
                            fval = {56'd0, b};
                        end
                    end
                endcase

                if (bad) begin
                    end_now = 1'b1;
                    status  = l2x_pkg::ST_BAD_LEN;
                end else if (rel == hdr_len - 8'd1) begin
                    ph = phase;
                    hdr_end = byte_off + 8'd1;
                    if (ph == l2x_pkg::PH_ETH || ph == l2x_pkg::PH_VLAN) begin
                        if (ph == l2x_pkg::PH_ETH && nxt_type == l2x_pkg::ETYPE_VLAN) begin
                            enter_header(l2x_pkg::PH_VLAN, l2x_pkg::LEN_VLAN);
                        end else if (nxt_type == l2x_pkg::ETYPE_IP4) begin
                            enter_header(l2x_pkg::PH_IP4, l2x_pkg::LEN_IP4);
                            l3_seen = l2x_pkg::L3_IP4;
                        end else if (nxt_type == l2x_pkg::ETYPE_IP6) begin
                            enter_header(l2x_pkg::PH_IP6, l2x_pkg::LEN_IP6);
                            l3_seen = l2x_pkg::L3_IP6;
                        end else begin
                            finish = 1'b1;
                        end
                    end else if (ph == l2x_pkg::PH_IP4 || ph == l2x_pkg::PH_IP6) begin
                        if (nxt_type == l2x_pkg::PROTO_UDP) begin
                            enter_header(l2x_pkg::PH_UDP, l2x_pkg::LEN_UDP);
                            l4_seen = l2x_pkg::L4_UDP;
                        end else if (nxt_type == l2x_pkg::PROTO_TCP) begin
                            enter_header(l2x_pkg::PH_TCP, l2x_pkg::LEN_TCP);
                            l4_seen = l2x_pkg::L4_TCP;
                        end else if (nxt_type == l2x_pkg::PROTO_ICMP &&
                                     ph == l2x_pkg::PH_IP4) begin
                            enter_header(l2x_pkg::PH_ICMP, l2x_pkg::LEN_ICMP);
                            l4_seen = l2x_pkg::L4_ICMP;
                        end else begin
                            finish = 1'b1;
                        end
                    end else begin
                        finish = 1'b1;
                    end
                    if (finish) begin
                        end_now = 1'b1;
                        status  = l2x_pkg::ST_OK;
                    end
                end
                if (!end_now && last) begin
                    end_now = 1'b1;
                    status  = l2x_pkg::ST_TRUNC;
                end
                if (end_now) begin
                    skipping = 1'b1;
                end
                if (byte_off != 8'hFF) begin
                    byte_off++;
                end
            end

            e_val = hdr_end;
            e_l3  = l3_seen;
            e_l4  = l4_seen;
            if (last) begin
                packets++;
                clear_packet();
            end

            // A held end record always goes out first; a fresh one is then held in turn.
            if (held) begin
                queue_record(l2x_pkg::FID_END, held_val, held_l3, held_l4, held_st, 1'b1);
                held = 1'b0;
            end else if (have_field) begin
                queue_record(fid, fval, f_l3, f_l4, l2x_pkg::ST_OK, 1'b0);
            end else if (end_now) begin
                queue_record(l2x_pkg::FID_END, {56'd0, e_val}, e_l3, e_l4, status, 1'b1);
                return;
            end else begin
                return;
            end
            if (end_now) begin
                held     = 1'b1;
                held_val = {56'd0, e_val};
                held_l3  = e_l3;
                held_l4  = e_l4;
                held_st  = status;
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (seen !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_record(field_record_t got);
            field_record_t want;
            if (awaited.size() == 0) begin
                $error("Result with nothing awaited: field_id %0d, field_value 0x%0h",
                       got.fid, got.val);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("field_id", 64'(want.fid), 64'(got.fid));
            compare_field("field_value", want.val, got.val);
            compare_field("l3_kind", 64'(want.l3), 64'(got.l3));
            compare_field("l4_kind", 64'(want.l4), 64'(got.l4));
            compare_field("parse_status", 64'(want.st), 64'(got.st));
            compare_field("headers_done", 64'(want.done), 64'(got.done));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_field_id;
    logic [63:0] m_field_value;
    logic [1:0]  m_l3_kind;
    logic [1:0]  m_l4_kind;
    logic [1:0]  m_parse_status;
    logic        m_headers_done;

    field_record_predictor sb;
    logic [7:0]  pkt[$];
    int          send_idle;
    int          recv_stall;
    int          driven_bytes;

    l2_l4_header_field_extractor_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_field_id     (m_field_id),
        .m_field_value  (m_field_value),
        .m_l3_kind      (m_l3_kind),
        .m_l4_kind      (m_l4_kind),
        .m_parse_status (m_parse_status),
        .m_headers_done (m_headers_done)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge aclk) begin
        field_record_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.take_byte(s_data_byte, s_last_byte);
            end
            if (m_valid && m_ready) begin
                got.fid  = m_field_id;
                got.val  = m_field_value;
                got.l3   = m_l3_kind;
                got.l4   = m_l4_kind;
                got.st   = m_parse_status;
                got.done = m_headers_done;
                sb.check_record(got);
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $error("No request moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [7:0] fill_byte(int fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom);
        endcase
    endfunction

    function automatic void make_packet(logic vlan, logic [15:0] etype, logic [3:0] ihl,
                                        logic [7:0] proto, logic [3:0] tcp_off,
                                        int payload, int cut_at, int fill);
        int         base;
        int         len;
        logic       has_l4;
        logic [7:0] tmp;
        pkt.delete();
        has_l4 = 1'b0;
        repeat (12) pkt.push_back(fill_byte(fill));
        if (vlan) begin
            pkt.push_back(l2x_pkg::ETYPE_VLAN[15:8]);
            pkt.push_back(l2x_pkg::ETYPE_VLAN[7:0]);
            repeat (2) pkt.push_back(fill_byte(fill));
        end
        pkt.push_back(etype[15:8]);
        pkt.push_back(etype[7:0]);
        if (etype == l2x_pkg::ETYPE_IP4) begin
            len = (ihl < l2x_pkg::MIN_HDR_WORDS) ? 20 : ihl * 4;
            base = pkt.size();
            repeat (len) pkt.push_back(fill_byte(fill));
            tmp = fill_byte(fill);
            pkt[base] = {tmp[7:4], ihl};
            pkt[base + 9] = proto;
            has_l4 = (ihl >= l2x_pkg::MIN_HDR_WORDS);
        end else if (etype == l2x_pkg::ETYPE_IP6) begin
            base = pkt.size();
            repeat (40) pkt.push_back(fill_byte(fill));
            pkt[base + 6] = proto;
            has_l4 = 1'b1;
        end
        if (has_l4 && (proto == l2x_pkg::PROTO_UDP[7:0] ||
                       proto == l2x_pkg::PROTO_ICMP[7:0])) begin
            repeat (8) pkt.push_back(fill_byte(fill));
        end else if (has_l4 && proto == l2x_pkg::PROTO_TCP[7:0]) begin
            len = (tcp_off < l2x_pkg::MIN_HDR_WORDS) ? 20 : tcp_off * 4;
            base = pkt.size();
            repeat (len) pkt.push_back(fill_byte(fill));
            tmp = fill_byte(fill);
            pkt[base + 12] = {tcp_off, tmp[3:0]};
        end
        repeat (payload) pkt.push_back(fill_byte(fill));
        if (cut_at > 0 && cut_at < pkt.size()) begin
            while (pkt.size() > cut_at) void'(pkt.pop_back());
        end
    endfunction

    task automatic push_byte(logic [7:0] d, logic last);
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < send_idle);
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        driven_bytes++;
    endtask

    task automatic send_packet();
        foreach (pkt[i]) begin
            push_byte(pkt[i], i == pkt.size() - 1);
        end
    endtask

    // A plain Ethernet frame of unknown type releases any held end record, then the
    // sender waits until every awaited result has been taken.
    task automatic settle();
        make_packet(1'b0, 16'h88B5, 4'd5, 8'd0, 4'd5, 0, 0, FILL_RANDOM);
        send_packet();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_directed();
        make_packet(1'b0, 16'h1234, 4'd5, 8'd0, 4'd5, 0, 0, FILL_ZERO);
        send_packet();
        make_packet(1'b0, l2x_pkg::ETYPE_IP4, 4'd5, l2x_pkg::PROTO_UDP[7:0], 4'd5, 0, 1,
                    FILL_ONES);
        send_packet();
        make_packet(1'b0, l2x_pkg::ETYPE_IP4, 4'd4, l2x_pkg::PROTO_TCP[7:0], 4'd5, 0, 16,
                    FILL_RANDOM);
        send_packet();
        make_packet(1'b0, l2x_pkg::ETYPE_IP4, 4'd5, l2x_pkg::PROTO_TCP[7:0], 4'd0, 0, 48,
                    FILL_ONES);
        send_packet();
        make_packet(1'b0, l2x_pkg::ETYPE_IP4, 4'd5, 8'd47, 4'd5, 0, 0, FILL_RANDOM);
        send_packet();
        make_packet(1'b0, l2x_pkg::ETYPE_IP6, 4'd5, l2x_pkg::PROTO_ICMP[7:0], 4'd5, 0, 54,
                    FILL_RANDOM);
        send_packet();
        make_packet(1'b0, l2x_pkg::ETYPE_IP6, 4'd5, l2x_pkg::PROTO_TCP[7:0], 4'd6, 0, 0,
                    FILL_RANDOM);
        send_packet();
        make_packet(1'b1, l2x_pkg::ETYPE_IP4, 4'd5, 8'd0, 4'd5, 0, 6, FILL_ZERO);
        send_packet();
        make_packet(1'b1, l2x_pkg::ETYPE_VLAN, 4'd5, 8'd0, 4'd5, 0, 0, FILL_RANDOM);
        send_packet();
    endtask

    task automatic random_packet();
        int         r;
        int         cut;
        int         fill;
        logic       vlan;
        logic [15:0] etype;
        logic [3:0] ihl;
        logic [3:0] off;
        logic [7:0] proto;

        r = $urandom_range(0, 99);
        if (r < 10) begin
            pkt.delete();
            repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
            send_packet();
            return;
        end
        vlan = ($urandom_range(0, 99) < 30);
        r = $urandom_range(0, 99);
        if (r < 45) etype = l2x_pkg::ETYPE_IP4;
        else if (r < 80) etype = l2x_pkg::ETYPE_IP6;
        else if (r < 88) etype = l2x_pkg::ETYPE_VLAN;
        else etype = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10) ihl = 4'($urandom_range(0, 4));
        else if (r < 70) ihl = 4'd5;
        else ihl = 4'($urandom_range(6, 15));
        r = $urandom_range(0, 99);
        if (r < 10) off = 4'($urandom_range(0, 4));
        else if (r < 70) off = 4'd5;
        else off = 4'($urandom_range(6, 15));
        r = $urandom_range(0, 99);
        if (r < 35) proto = l2x_pkg::PROTO_TCP[7:0];
        else if (r < 65) proto = l2x_pkg::PROTO_UDP[7:0];
        else if (r < 85) proto = l2x_pkg::PROTO_ICMP[7:0];
        else proto = 8'($urandom);
        cut = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 90) : 0;
        r = $urandom_range(0, 99);
        fill = (r < 5) ? FILL_ZERO : (r < 10) ? FILL_ONES : FILL_RANDOM;
        make_packet(vlan, etype, ihl, proto, off, $urandom_range(0, 6), cut, fill);
        send_packet();
    endtask

    initial begin
        int phase_mark;
        sb = new;
        sb.reset_all();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data_byte  = 8'd0;
        s_last_byte  = 1'b0;
        m_ready      = 1'b0;
        send_idle    = 0;
        recv_stall   = 0;
        driven_bytes = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        settle();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 46; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 46; end
                default: begin send_idle = 35; recv_stall = 35; end
            endcase
            phase_mark = driven_bytes;
            while (driven_bytes - phase_mark < PHASE_BYTES) random_packet();
            settle();
        end

        repeat (4) @(posedge aclk);
        $display("Sent %0d packets in %0d bytes under four idling mixes.",
                 sb.packets, driven_bytes);
        $display("Checked %0d header fields and %0d/%0d/%0d ok/truncated/bad-length ends.",
                 sb.field_count, sb.ok_ends, sb.trunc_ends, sb.bad_ends);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
